[hdl/cslm_pkg.sv]
// Package for the crane safe-load monitor: sequencer step codes, the command and
// status words between controller and datapath, the load chart and the cosine table.
// No dependencies.
`default_nettype none
package cslm_pkg;

  localparam int STEP_W = 4;

  // Sequencer steps, shared by controller (as state) and datapath (as command)
  localparam logic [STEP_W-1:0] ST_ACC    = 4'd0;
  localparam logic [STEP_W-1:0] ST_DIV0   = 4'd1;
  localparam logic [STEP_W-1:0] ST_DIV1   = 4'd2;
  localparam logic [STEP_W-1:0] ST_SCALE  = 4'd3;
  localparam logic [STEP_W-1:0] ST_ADDR   = 4'd4;
  localparam logic [STEP_W-1:0] ST_ROM    = 4'd5;
  localparam logic [STEP_W-1:0] ST_MUL    = 4'd6;
  localparam logic [STEP_W-1:0] ST_RAD    = 4'd7;
  localparam logic [STEP_W-1:0] ST_SEARCH = 4'd8;
  localparam logic [STEP_W-1:0] ST_PREP   = 4'd9;
  localparam logic [STEP_W-1:0] ST_DIVIDE = 4'd10;
  localparam logic [STEP_W-1:0] ST_FIN    = 4'd11;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              acc;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic hit;
    logic seg_last;
    logic div_last;
  } sts_t;

  // Configuration register indexes
  localparam logic [1:0] REG_BOOM   = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  // Load chart: radius in mm, safe load in decitonnes; unused slots read as zero
  localparam int CHART_SLOTS = 32;
  localparam int SEG_W       = 5;
  localparam int CHART_R [CHART_SLOTS] = '{0: 3600, 1: 4000, 2: 4500, 3: 5000, 4: 6000,
                                          5: 7000, 6: 8000, 7: 9000, 8: 10000, 9: 11300,
                                          default: 0};
  localparam int CHART_L [CHART_SLOTS] = '{0: 500, 1: 500, 2: 434, 3: 365, 4: 276,
                                          5: 221, 6: 184, 7: 157, 8: 137, 9: 117,
                                          default: 0};

  // Cosine table, 0.1 degree steps, Q1.15
  localparam int COS_DEPTH = 1024;
  localparam int COS_AW    = 10;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Taylor term denominators (2n-1)*2n for n = 1..12
  localparam longint unsigned TAYLOR_DEN [12] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                                  64'd132, 64'd182, 64'd240, 64'd306,
                                                  64'd380, 64'd462, 64'd552};

  typedef logic signed [15:0] cos_tab_t [COS_DEPTH];

  function automatic logic signed [15:0] cos_entry(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint unsigned u;
    longint          sm;
    longint          c;
    x   = (longint'(k) * PI_Q30) / 64'd1800;
    x2  = (x * x) >> 30;
    mag = 64'd1 << 30;
    sm  = longint'(mag);
    for (int n = 1; n <= 12; n++) begin
      mag = ((mag * x2) >> 30) / TAYLOR_DEN[n-1];
      if ((n % 2) == 1) sm = sm - longint'(mag);
      else              sm = sm + longint'(mag);
    end
    if (sm < -(64'sd1 <<< 30)) sm = -(64'sd1 <<< 30);
    u = longint'(sm + (64'sd1 <<< 30) + (64'sd1 <<< 14)) >> 15;
    c = longint'(u) - 64'sd32768;
    if (c > 64'sd32767) c = 64'sd32767;
    return c[15:0];
  endfunction

  function automatic cos_tab_t build_cos();
    cos_tab_t t;
    for (int k = 0; k < COS_DEPTH; k++) t[k] = cos_entry(k);
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos();

endpackage
`default_nettype wire

[hdl/crane_safe_load_monitor.sv]
// Top level of the crane safe-load monitor: configuration registers and the
// controller and datapath. Depends on cslm_pkg, cslm_ctrl and cslm_datapath.
//
//   channel | direction | handshake            | word
//   in      | into      | in_valid / in_ready  | angle_sample, load_sample
//   out     | out of    | out_valid / out_ready| angle_cdeg .. angle_over_limit
//   cfg     | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Input words are summed at one a cycle while in_ready is high. The word that completes
// a group starts the group sequence: averaging, scaling, cosine lookup and radius, then
// chart search; if a chart segment holds the radius, the interpolation divider follows
// (restoring, one quotient bit a cycle), else the safe load is zero. Last the result
// word is written; in_ready is low throughout.
// The result register frees the sequencer unless an older word is still unread.
// Reset (rst, synchronous) loads the register defaults and empties the sums.
// The cfg channel never stalls; writes beyond the register list are dropped.
`default_nettype none
module crane_safe_load_monitor #(
  parameter int SAMPLES_PER_GROUP = 10,
  parameter int CHART_POINTS      = 10
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [11:0]  angle_sample,
  input  wire logic [11:0]  load_sample,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [13:0]       angle_cdeg,
  output logic signed [17:0] radius_mm,
  output logic [9:0]        load_dton,
  output logic [8:0]        safe_load_dton,
  output logic              overload,
  output logic              angle_over_limit,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import cslm_pkg::*;

  logic [15:0]        boom_length_mm;
  logic signed [15:0] slew_offset_mm;
  logic [13:0]        angle_limit_cdeg;
  cmd_t               cmd;
  sts_t               sts;

  assign cfg_ready = 1'b1;

  // Register file: hold until written, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      boom_length_mm   <= 16'd11300;
      slew_offset_mm   <= 16'sd0;
      angle_limit_cdeg <= 14'd8000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOOM:   boom_length_mm   <= cfg_data;
        REG_OFFSET: slew_offset_mm   <= cfg_data;
        REG_LIMIT:  angle_limit_cdeg <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  cslm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cslm_datapath #(
    .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP),
    .CHART_POINTS      (CHART_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .angle_sample     (angle_sample),
    .load_sample      (load_sample),
    .boom_length_mm   (boom_length_mm),
    .slew_offset_mm   (slew_offset_mm),
    .angle_limit_cdeg (angle_limit_cdeg),
    .angle_cdeg       (angle_cdeg),
    .radius_mm        (radius_mm),
    .load_dton        (load_dton),
    .safe_load_dton   (safe_load_dton),
    .overload         (overload),
    .angle_over_limit (angle_over_limit)
  );

endmodule
`default_nettype wire

[hdl/cslm_ctrl.sv]
// Sequencer for the crane safe-load monitor: steps the datapath through a group.
// Depends on cslm_pkg.
`default_nettype none
module cslm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire cslm_pkg::sts_t sts,
  output cslm_pkg::cmd_t     cmd
);
  import cslm_pkg::*;

  logic [STEP_W-1:0] state, state_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_ACC);

  always_comb begin
    cmd.step     = state;
    cmd.acc      = (state == ST_ACC) && in_valid;
    cmd.load_out = (state == ST_FIN) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACC:    if (in_valid && sts.cnt_last) state_next = ST_DIV0;
      ST_DIV0:   state_next = ST_DIV1;
      ST_DIV1:   state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_ADDR;
      ST_ADDR:   state_next = ST_ROM;
      ST_ROM:    state_next = ST_MUL;
      ST_MUL:    state_next = ST_RAD;
      ST_RAD:    state_next = ST_SEARCH;
      ST_SEARCH: begin
        priority if (sts.hit) state_next = ST_PREP;
        else if (sts.seg_last) state_next = ST_FIN;
        else state_next = ST_SEARCH;
      end
      ST_PREP:   state_next = ST_DIVIDE;
      ST_DIVIDE: if (sts.div_last) state_next = ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_ACC;
      default:   state_next = ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[hdl/cslm_datapath.sv]
// Datapath for the crane safe-load monitor: accumulators, scaling, cosine table,
// radius, chart search, interpolation divider and result word. Depends on cslm_pkg.
`default_nettype none
module cslm_datapath #(
  parameter int SAMPLES_PER_GROUP = 10,
  parameter int CHART_POINTS      = 10
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cslm_pkg::cmd_t      cmd,
  output cslm_pkg::sts_t           sts,
  input  wire logic [11:0]         angle_sample,
  input  wire logic [11:0]         load_sample,
  input  wire logic [15:0]         boom_length_mm,
  input  wire logic signed [15:0]  slew_offset_mm,
  input  wire logic [13:0]         angle_limit_cdeg,
  output logic [13:0]              angle_cdeg,
  output logic signed [17:0]       radius_mm,
  output logic [9:0]               load_dton,
  output logic [8:0]               safe_load_dton,
  output logic                     overload,
  output logic                     angle_over_limit
);
  import cslm_pkg::*;

  localparam int CNT_W = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;
  localparam int RECIP = (1 << 20) / SAMPLES_PER_GROUP;
  localparam int DW    = 30;

  // accumulation
  logic [15:0]       asum, lsum;
  logic [CNT_W-1:0]  count;
  // group pipeline
  logic [15:0]       qa0, ql0;
  logic [11:0]       a_avg, l_avg;
  logic [13:0]       angle;
  logic [9:0]        load;
  logic [COS_AW-1:0] rom_addr;
  logic signed [15:0] cos_q;
  logic signed [32:0] prod;
  logic signed [17:0] radius;
  // search and interpolation
  logic [SEG_W-1:0]  seg;
  logic              found, eq;
  logic signed [10:0] l0, dl;
  logic signed [18:0] dr;
  logic [17:0]       den;
  logic              neg;
  logic [DW-1:0]     quo;
  logic [17:0]       rem;
  logic [4:0]        dcnt;

  logic [36:0]       a_mul, l_mul;
  logic [19:0]       a_rem, l_rem;
  logic [25:0]       ang_mul;
  logic [21:0]       ld_mul;
  logic [27:0]       addr_mul;
  logic signed [18:0] rad_sum;
  int                r0, r1, rad_i;
  logic              hit;
  logic signed [DW-1:0] num;
  logic [18:0]       trial;
  logic              ge;
  logic signed [31:0] qs, v;
  logic [8:0]        safe;

  assign a_mul    = {21'd0, asum} * 37'(RECIP);
  assign l_mul    = {21'd0, lsum} * 37'(RECIP);
  assign a_rem    = {4'd0, asum} - 20'(qa0 * 20'(SAMPLES_PER_GROUP));
  assign l_rem    = {4'd0, lsum} - 20'(ql0 * 20'(SAMPLES_PER_GROUP));
  assign ang_mul  = {14'd0, a_avg} * 26'd10100;
  assign ld_mul   = {10'd0, l_avg} * 22'd1010;
  // angle / 10 by reciprocal; exact for angles below 16384
  assign addr_mul = {14'd0, angle} * 28'd6554;
  assign rad_sum  = 19'(prod[32:15]) + 19'(slew_offset_mm);

  assign r0    = CHART_R[seg];
  assign r1    = CHART_R[seg + SEG_W'(1)];
  assign rad_i = int'(radius);
  assign hit   = (r0 <= rad_i) && (rad_i <= r1);
  assign num   = DW'(dl * dr);

  assign trial = {rem, quo[DW-1]};
  assign ge    = trial >= {1'b0, den};

  assign qs = neg ? -(32'(quo) + 32'(rem != 18'd0)) : 32'(quo);
  assign v  = 32'(l0) + qs;

  always_comb begin
    priority if (!found) safe = 9'd0;
    else if (eq) safe = 9'(l0);
    else if (v < 0) safe = 9'd0;
    else if (v > 511) safe = 9'd511;
    else safe = v[8:0];
  end

  assign sts.cnt_last = (count == CNT_W'(SAMPLES_PER_GROUP - 1));
  assign sts.hit      = hit;
  assign sts.seg_last = (seg == SEG_W'(CHART_POINTS - 2));
  assign sts.div_last = (dcnt == 5'(DW - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      asum  <= 16'd0;
      lsum  <= 16'd0;
      count <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.acc) begin
        asum <= asum + {4'd0, angle_sample};
        lsum <= lsum + {4'd0, load_sample};
        if (sts.cnt_last) count <= '0;
        else count <= count + CNT_W'(1);
      end
      unique case (cmd.step)
        ST_DIV1: begin
          asum <= 16'd0;
          lsum <= 16'd0;
        end
        ST_RAD: found <= 1'b0;
        ST_SEARCH: if (hit) found <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.step)
      ST_DIV0: begin
        qa0 <= a_mul[35:20];
        ql0 <= l_mul[35:20];
      end
      ST_DIV1: begin
        a_avg <= 12'(qa0 + 16'(a_rem >= 20'(SAMPLES_PER_GROUP)));
        l_avg <= 12'(ql0 + 16'(l_rem >= 20'(SAMPLES_PER_GROUP)));
      end
      ST_SCALE: begin
        angle <= ang_mul[25:12];
        load  <= ld_mul[21:12];
      end
      ST_ADDR: rom_addr <= addr_mul[16 +: COS_AW];
      ST_ROM:  cos_q <= COS_TAB[rom_addr];
      ST_MUL:  prod <= $signed({17'd0, boom_length_mm}) * 33'(cos_q);
      ST_RAD: begin
        radius <= rad_sum[17:0];
        seg    <= '0;
      end
      ST_SEARCH: begin
        if (hit) begin
          eq  <= (r0 == r1);
          l0  <= 11'(CHART_L[seg]);
          dl  <= 11'(CHART_L[seg + SEG_W'(1)] - CHART_L[seg]);
          dr  <= 19'(rad_i - r0);
          den <= 18'(r1 - r0);
        end else begin
          seg <= seg + SEG_W'(1);
        end
      end
      ST_PREP: begin
        neg  <= num < 0;
        quo  <= (num < 0) ? DW'(-num) : DW'(num);
        rem  <= 18'd0;
        dcnt <= 5'd0;
      end
      ST_DIVIDE: begin
        rem  <= ge ? 18'(trial - {1'b0, den}) : trial[17:0];
        quo  <= {quo[DW-2:0], ge};
        dcnt <= dcnt + 5'd1;
      end
      default: ;
    endcase
    if (cmd.load_out) begin
      angle_cdeg       <= angle;
      radius_mm        <= radius;
      load_dton        <= load;
      safe_load_dton   <= safe;
      overload         <= {1'b0, load} > {2'b00, safe};
      angle_over_limit <= angle > angle_limit_cdeg;
    end
  end

endmodule
`default_nettype wire

[hdl/cslm_checker.sv]
// Port-level checks for the crane safe-load monitor, bound to the top level.
// Depends on crane_safe_load_monitor.
`default_nettype none
module cslm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [13:0] angle_cdeg,
  input wire logic [9:0]  load_dton,
  input wire logic [8:0]  safe_load_dton,
  input wire logic        overload
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_cdeg) && $stable(load_dton))
    else $error("result word changed while stalled");

  a_overload: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> overload == ({1'b0, load_dton} > {2'b00, safe_load_dton}))
    else $error("overload flag disagrees with load and safe load");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle_cdeg <= 14'd10098)
    else $error("angle out of range");

  a_load_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> load_dton <= 10'd1009 && safe_load_dton <= 9'd500)
    else $error("load out of range");

endmodule

bind crane_safe_load_monitor cslm_checker u_cslm_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .angle_cdeg     (angle_cdeg),
  .load_dton      (load_dton),
  .safe_load_dton (safe_load_dton),
  .overload       (overload)
);
`default_nettype wire
